[hw/rtl/srr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// srr_pkg - shared types and constants of the stereo resampler
// Status codes, opcode values and the control bundle passed from the front
// end to the rest of the block.
// ============================================================================
package srr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 24;

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

    // opcodes
    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // frames needed ahead of the read index before a request may interpolate
    localparam int MIN_AHEAD = 2;

    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_PRODUCED = 2'd2,
        ST_UNDERRUN = 2'd3
    } t_status;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_item_ctl;

endpackage

[hw/rtl/stereo_linear_resampler_ring.sv]
`timescale 1ns / 1ps
// ============================================================================
// stereo_linear_resampler_ring - stereo linear-interpolation rate converter
// Source frame ring with push and request items, queue-style ports.
// ============================================================================
// Usage: push items with opcode 0 to store a stereo source frame, opcode 1 to
// ask for one output frame interpolated at the current play position, which
// then moves on by the step register (Q8.16 source frames per output frame by
// default). Every transfer in gives exactly one result, in order, with a
// status: stored, dropped (ring full), produced or underrun (zeros, position
// held). The block takes one item per clock and delivers one result per clock
// while pop keeps up; a result passes the front register and ring read, the
// middle queue, multiply stage and result queue on its way out. The rate is
// set by the front end, which updates the ring indices and play position once
// per item, and by the dual-read ring memory, which fetches both neighbouring
// frames in the same cycle. After reset and after each step write, full stays
// high while the step's integer part is reduced modulo the ring depth by a
// two-stage reciprocal multiplication. Write the step only with the block
// idle. There is no clearing pass; produced results use only written entries.
// ============================================================================
module stereo_linear_resampler_ring
    import srr_pkg::*;
#(
    parameter int RING_DEPTH = 4096,
    parameter int FRAC_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input side
    input  logic                push,
    output logic                full,
    input  logic                i_opcode,
    input  logic [SAMPLE_W-1:0] i_left_sample,
    input  logic [SAMPLE_W-1:0] i_right_sample,
    // result side
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          o_status,
    output logic [SAMPLE_W-1:0] o_left_out,
    output logic [SAMPLE_W-1:0] o_right_out,
    // step register write
    input  logic                i_cfg_we,
    input  logic [STEP_W-1:0]   i_cfg_wdata
);

    localparam int AW       = $clog2(RING_DEPTH);
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int MQ_DEPTH = 4;
    localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);
    localparam int MQ_W     = 2 + FRAC_BITS + 2 * FRAME_W;

    // ring memory port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [FRAME_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr_a;
    logic [AW-1:0]        ram_raddr_b;
    logic [FRAME_W-1:0]   ram_rdata_a;
    logic [FRAME_W-1:0]   ram_rdata_b;

    // front to middle queue
    t_item_ctl            front_ctl;
    logic [FRAC_BITS-1:0] front_frac;
    logic [MQ_W-1:0]      mq_wdata;
    logic [MQ_W-1:0]      mq_rdata;
    logic                 mq_empty;
    logic [MQ_CW-1:0]     mq_count;
    logic                 mq_pop;

    // front end: classifies items in order, owns indices and position
    srr_front #(
        .RING_DEPTH (RING_DEPTH),
        .FRAC_BITS  (FRAC_BITS),
        .Q_DEPTH    (MQ_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_opcode       (i_opcode),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_count      (mq_count),
        .o_full         (full),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr_a  (ram_raddr_a),
        .o_ram_raddr_b  (ram_raddr_b),
        .o_ctl          (front_ctl),
        .o_frac         (front_frac)
    );

    // frame ring, left sample in the low half
    srr_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // read data arrives with the registered status, both enter the queue
    assign mq_wdata = {front_ctl.status, front_frac, ram_rdata_a, ram_rdata_b};

    // middle queue: front credit counts the entry still in flight
    srr_queue #(
        .WIDTH (MQ_W),
        .DEPTH (MQ_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_ctl.valid),
        .i_data  (mq_wdata),
        .i_pop   (mq_pop),
        .o_data  (mq_rdata),
        .o_empty (mq_empty),
        .o_count (mq_count)
    );

    // back end: interpolation and result queue
    srr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (mq_empty),
        .i_q_status  (t_status'(mq_rdata[MQ_W-1 -: 2])),
        .i_q_frac    (mq_rdata[2*FRAME_W +: FRAC_BITS]),
        .i_q_frame_a (mq_rdata[FRAME_W +: FRAME_W]),
        .i_q_frame_b (mq_rdata[0 +: FRAME_W]),
        .o_q_pop     (mq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_status    (o_status),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

endmodule

[hw/rtl/srr_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// srr_ram - generic RAM, one write port, two registered read ports
// ============================================================================
module srr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[hw/rtl/srr_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// srr_queue - small register queue with occupancy count
// Caller pushes only when there is room and pops only when not empty.
// ============================================================================
module srr_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    n_rptr;
    logic [CW-1:0]    n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

[hw/rtl/srr_step_mod.sv]
`timescale 1ns / 1ps
// ============================================================================
// srr_step_mod - remainder of the step's integer part by the ring depth
// Quotient by reciprocal multiplication, then multiply back and subtract;
// two register stages.
// ============================================================================
module srr_step_mod #(
    parameter int INT_W = 9,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [INT_W-1:0]         i_value,
    output logic                     o_busy,
    output logic [$clog2(DEPTH)-1:0] o_rem
);

    localparam int AW    = $clog2(DEPTH);
    localparam int SHIFT = INT_W + AW;
    localparam int MUL_W = 2 * INT_W + 1;
    localparam int EXT_W = SHIFT + INT_W;
    // ceil(2^SHIFT / DEPTH), exact quotient for every value below 2^INT_W
    localparam logic [63:0] RECIP_L =
        ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [MUL_W-1:0] RECIP   = MUL_W'(RECIP_L);
    localparam logic [INT_W-1:0] DEPTH_N = INT_W'(DEPTH);

    logic             r_busy;
    logic [INT_W-1:0] r_val;
    logic [INT_W-1:0] r_quo;
    logic [AW-1:0]    r_rem;
    logic [MUL_W-1:0] prod;
    logic [EXT_W-1:0] prod_ext;
    logic [INT_W-1:0] quo;
    logic [INT_W-1:0] rem_full;

    always_comb begin
        prod     = MUL_W'(i_value) * RECIP;
        prod_ext = EXT_W'(prod);
        quo      = prod_ext[SHIFT +: INT_W];
        // quotient times depth never exceeds the value, so INT_W bits suffice
        rem_full = r_val - r_quo * DEPTH_N;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_quo <= quo;
        end
        if (r_busy) begin
            r_rem <= AW'(rem_full);
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/srr_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// srr_front - front end: step register, ring indices and item classification
// Decides each item's status in order, writes stored frames and issues the
// two ring reads for a request in the cycle of the transfer.
// ============================================================================
module srr_front
    import srr_pkg::*;
#(
    parameter int RING_DEPTH = 4096,
    parameter int FRAC_BITS  = 16,
    parameter int Q_DEPTH    = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_opcode,
    input  logic [SAMPLE_W-1:0]            i_left_sample,
    input  logic [SAMPLE_W-1:0]            i_right_sample,
    input  logic                           i_cfg_we,
    input  logic [STEP_W-1:0]              i_cfg_wdata,
    input  logic [$clog2(Q_DEPTH+1)-1:0]   i_q_count,
    output logic                           o_full,
    output logic                           o_ram_we,
    output logic [$clog2(RING_DEPTH)-1:0]  o_ram_waddr,
    output logic [2*SAMPLE_W-1:0]          o_ram_wdata,
    output logic [$clog2(RING_DEPTH)-1:0]  o_ram_raddr_a,
    output logic [$clog2(RING_DEPTH)-1:0]  o_ram_raddr_b,
    output t_item_ctl                      o_ctl,
    output logic [FRAC_BITS-1:0]           o_frac
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int INT_W = STEP_W + 1 - FRAC_BITS;
    localparam int QCW   = $clog2(Q_DEPTH + 1);
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(RING_DEPTH);
    localparam logic [AW:0] WRAP_C  = (AW + 1)'(64'h1_0000_0000 % RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic signed [31:0] DEPTH_S = 32'(RING_DEPTH);
    localparam logic signed [31:0] AHEAD_S = 32'(MIN_AHEAD);

    logic [STEP_W-1:0]    r_step;
    logic                 r_cfg_pending;
    logic [31:0]          r_write_index;
    logic [AW-1:0]        r_write_slot;
    logic [31:0]          r_base;
    logic [FRAC_BITS-1:0] r_frac;
    logic [AW-1:0]        r_base_slot;
    t_item_ctl            r_ctl;
    logic [FRAC_BITS-1:0] r_s1_frac;

    logic                 mod_busy;
    logic [AW-1:0]        step_mod;
    logic [INT_W-1:0]     step_int;
    logic                 accept;
    logic                 is_req;
    logic [31:0]          lead;
    logic                 has_room;
    logic                 has_pair;
    logic                 do_store;
    logic                 do_advance;
    t_status              status;
    logic [FRAC_BITS:0]   frac_sum;
    logic [32:0]          base_sum;
    logic [AW:0]          slot_t1;
    logic [AW:0]          slot_t2;
    logic [AW:0]          slot_t3;
    logic [AW-1:0]        base_slot_p1;
    logic [AW-1:0]        n_write_slot;

    assign step_int = INT_W'({1'b0, r_step} >> FRAC_BITS);

    srr_step_mod #(
        .INT_W (INT_W),
        .DEPTH (RING_DEPTH)
    ) u_step_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cfg_pending),
        .i_value (step_int),
        .o_busy  (mod_busy),
        .o_rem   (step_mod)
    );

    assign o_full = r_cfg_pending || mod_busy
                 || ((QCW + 1)'(i_q_count) + (QCW + 1)'(r_ctl.valid)
                     >= (QCW + 1)'(Q_DEPTH));

    always_comb begin
        accept     = i_push && !o_full;
        is_req     = (i_opcode == OP_REQUEST);
        lead       = r_write_index - r_base;
        has_room   = $signed(lead) < DEPTH_S;
        has_pair   = $signed(lead) >= AHEAD_S;
        do_store   = accept && !is_req && has_room;
        do_advance = accept && is_req && has_pair;

        if (!is_req) begin
            status = has_room ? ST_STORED : ST_DROPPED;
        end else begin
            status = has_pair ? ST_PRODUCED : ST_UNDERRUN;
        end

        // position advance, slot tracked alongside the 32-bit index
        frac_sum = {1'b0, r_frac} + {1'b0, r_step[FRAC_BITS-1:0]};
        base_sum = {1'b0, r_base} + 33'(step_int) + 33'(frac_sum[FRAC_BITS]);

        slot_t1 = {1'b0, r_base_slot} + {1'b0, step_mod};
        if (slot_t1 >= DEPTH_C) begin
            slot_t1 = slot_t1 - DEPTH_C;
        end
        slot_t2 = slot_t1 + (AW + 1)'(frac_sum[FRAC_BITS]);
        if (slot_t2 == DEPTH_C) begin
            slot_t2 = '0;
        end
        // index wrap at 2^32 shifts the slot by 2^32 mod depth
        slot_t3 = slot_t2;
        if (base_sum[32]) begin
            slot_t3 = (slot_t2 >= WRAP_C) ? slot_t2 - WRAP_C
                                          : slot_t2 + DEPTH_C - WRAP_C;
        end

        base_slot_p1 = (r_base_slot == LAST_SLOT || r_base == '1) ? '0
                     : r_base_slot + 1'b1;
        n_write_slot = (r_write_slot == LAST_SLOT || r_write_index == '1) ? '0
                     : r_write_slot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= STEP_RESET;
            r_cfg_pending <= 1'b1;
            r_write_index <= '0;
            r_write_slot  <= '0;
            r_base        <= '0;
            r_frac        <= '0;
            r_base_slot   <= '0;
            r_ctl         <= '{valid: 1'b0, status: ST_STORED};
        end else begin
            if (i_cfg_we) begin
                r_step        <= i_cfg_wdata;
                r_cfg_pending <= 1'b1;
            end else begin
                r_cfg_pending <= 1'b0;
            end
            if (do_store) begin
                r_write_index <= r_write_index + 1'b1;
                r_write_slot  <= n_write_slot;
            end
            if (do_advance) begin
                r_base      <= base_sum[31:0];
                r_frac      <= frac_sum[FRAC_BITS-1:0];
                r_base_slot <= slot_t3[AW-1:0];
            end
            r_ctl.valid  <= accept;
            r_ctl.status <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_frac <= r_frac;
    end

    assign o_ram_we      = do_store;
    assign o_ram_waddr   = r_write_slot;
    assign o_ram_wdata   = {i_right_sample, i_left_sample};
    assign o_ram_raddr_a = r_base_slot;
    assign o_ram_raddr_b = base_slot_p1;
    assign o_ctl         = r_ctl;
    assign o_frac        = r_s1_frac;

endmodule

[hw/rtl/srr_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// srr_back - back end: interpolation, rounding and result queue
// Multiply stage, then round half to even and clamp into the result queue.
// ============================================================================
module srr_back
    import srr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_status                i_q_status,
    input  logic [FRAC_BITS-1:0]   i_q_frac,
    input  logic [2*SAMPLE_W-1:0]  i_q_frame_a,
    input  logic [2*SAMPLE_W-1:0]  i_q_frame_b,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [1:0]             o_status,
    output logic [SAMPLE_W-1:0]    o_left_out,
    output logic [SAMPLE_W-1:0]    o_right_out
);

    localparam int PROD_W   = FRAC_BITS + 18;
    localparam int NUM_W    = FRAC_BITS + 19;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
    localparam int OQ_W     = 2 + 2 * SAMPLE_W;
    localparam logic signed [NUM_W-1:0] S_MAX = NUM_W'(32767);
    localparam logic signed [NUM_W-1:0] S_MIN = NUM_W'(-32768);
    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    function automatic logic [SAMPLE_W-1:0] f_round(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [PROD_W-1:0]   prod
    );
        logic signed [SAMPLE_W+FRAC_BITS-1:0] a_sh;
        logic signed [NUM_W-1:0]              num;
        logic signed [NUM_W-1:0]              q;
        logic signed [NUM_W-1:0]              v;
        logic [FRAC_BITS-1:0]                 rem;
        logic                                 up;
        a_sh = $signed({a, {FRAC_BITS{1'b0}}});
        num  = NUM_W'(a_sh) + NUM_W'(prod);
        q    = num >>> FRAC_BITS;
        rem  = num[FRAC_BITS-1:0];
        up   = (rem > HALF) || (rem == HALF && q[0]);
        v    = q + $signed(NUM_W'(up));
        if (v > S_MAX) begin
            v = S_MAX;
        end else if (v < S_MIN) begin
            v = S_MIN;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    logic                          r_m_valid;
    t_status                       r_m_status;
    logic signed [SAMPLE_W-1:0]    r_m_a_l;
    logic signed [SAMPLE_W-1:0]    r_m_a_r;
    logic signed [PROD_W-1:0]      r_m_prod_l;
    logic signed [PROD_W-1:0]      r_m_prod_r;

    logic signed [SAMPLE_W:0]      diff_l;
    logic signed [SAMPLE_W:0]      diff_r;
    logic signed [PROD_W-1:0]      diff_l_ext;
    logic signed [PROD_W-1:0]      diff_r_ext;
    logic signed [PROD_W-1:0]      frac_ext;
    logic [OQ_CW-1:0]              oq_count;
    logic [OQ_W-1:0]               oq_wdata;
    logic [OQ_W-1:0]               oq_rdata;
    logic                          oq_pop;
    logic [SAMPLE_W-1:0]           left_val;
    logic [SAMPLE_W-1:0]           right_val;

    // take from the middle queue only with a result slot reserved
    assign o_q_pop = !i_q_empty
                  && ((OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(r_m_valid)
                      < (OQ_CW + 1)'(OQ_DEPTH));

    always_comb begin
        diff_l = $signed({i_q_frame_b[SAMPLE_W-1], i_q_frame_b[SAMPLE_W-1:0]})
               - $signed({i_q_frame_a[SAMPLE_W-1], i_q_frame_a[SAMPLE_W-1:0]});
        diff_r = $signed({i_q_frame_b[2*SAMPLE_W-1], i_q_frame_b[2*SAMPLE_W-1:SAMPLE_W]})
               - $signed({i_q_frame_a[2*SAMPLE_W-1], i_q_frame_a[2*SAMPLE_W-1:SAMPLE_W]});
        diff_l_ext = PROD_W'(diff_l);
        diff_r_ext = PROD_W'(diff_r);
        frac_ext   = $signed(PROD_W'(i_q_frac));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= o_q_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_m_status <= i_q_status;
            r_m_a_l    <= $signed(i_q_frame_a[SAMPLE_W-1:0]);
            r_m_a_r    <= $signed(i_q_frame_a[2*SAMPLE_W-1:SAMPLE_W]);
            r_m_prod_l <= diff_l_ext * frac_ext;
            r_m_prod_r <= diff_r_ext * frac_ext;
        end
    end

    always_comb begin
        left_val  = '0;
        right_val = '0;
        if (r_m_status == ST_PRODUCED) begin
            left_val  = f_round(r_m_a_l, r_m_prod_l);
            right_val = f_round(r_m_a_r, r_m_prod_r);
        end
        oq_wdata = {r_m_status, left_val, right_val};
    end

    assign oq_pop = i_pop && !o_empty;

    srr_queue #(
        .WIDTH (OQ_W),
        .DEPTH (OQ_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_m_valid),
        .i_data  (oq_wdata),
        .i_pop   (oq_pop),
        .o_data  (oq_rdata),
        .o_empty (o_empty),
        .o_count (oq_count)
    );

    assign o_status    = oq_rdata[OQ_W-1 -: 2];
    assign o_left_out  = oq_rdata[SAMPLE_W +: SAMPLE_W];
    assign o_right_out = oq_rdata[0 +: SAMPLE_W];

endmodule

[hw/rtl/srr_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// srr_checker - port-level checks for the stereo resampler
// Attached to the top level by a bind statement below.
// ============================================================================
module srr_checker
    import srr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_full,
    input logic                i_empty,
    input logic                i_pop,
    input logic                i_cfg_we,
    input logic [1:0]          i_status,
    input logic [SAMPLE_W-1:0] i_left_out,
    input logic [SAMPLE_W-1:0] i_right_out
);

    // out of reset: nothing queued and input held off for the step reduction
    a_reset_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (i_empty && i_full))
        else $error("srr: not empty and full after reset");

    // a step write stalls the input while the remainder is recomputed
    a_cfg_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> i_full)
        else $error("srr: input open right after step write");

    // only produced results carry samples
    a_zero_samples : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_status != ST_PRODUCED) |-> (i_left_out == '0 && i_right_out == '0))
        else $error("srr: non-zero samples without produced status");

    // a waiting result holds until its transfer
    a_result_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_status)
                                  && $stable(i_left_out) && $stable(i_right_out)))
        else $error("srr: waiting result changed");

endmodule

bind stereo_linear_resampler_ring srr_checker u_srr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_full      (full),
    .i_empty     (empty),
    .i_pop       (pop),
    .i_cfg_we    (i_cfg_we),
    .i_status    (o_status),
    .i_left_out  (o_left_out),
    .i_right_out (o_right_out)
);
